// ----- sv/arf_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and state codes for the audio ring fifo with prefill
package arf_pkg;

    // storage geometry
    localparam int FIFO_DEPTH = 4096;
    localparam int ADDR_W     = $clog2(FIFO_DEPTH);
    localparam int PTR_W      = ADDR_W + 1;

    // field widths fixed by the interface
    localparam int SAMPLE_W   = 32;
    localparam int LEN_W      = 13;
    localparam int THR_W      = 13;
    localparam int LEVEL_W    = 13;

    // width wide enough to compare fill, free space, length and threshold
    localparam int CMP_W      = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;

    localparam logic [THR_W-1:0] PREFILL_RESET = THR_W'(2400);

    // mode codes
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_PULL = 1'b1;

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CMP_W-1:0]  cmp_t;

    // one input beat
    typedef struct packed {
        logic                mode;
        logic [SAMPLE_W-1:0] sample_in;
        logic                batch_first;
        logic [LEN_W-1:0]    batch_length;
    } item_t;

    // one result beat
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_out;
        logic                batch_dropped;
        logic                underrun;
        logic [LEVEL_W-1:0]  fill_level;
    } result_t;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_OUT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic exec;
        logic load;
    } ctrl_cmd_t;

endpackage

// ----- sv/arf_ctrl.sv -----
`timescale 1ns / 1ps
// controller state machine: input acceptance and result register handoff
module arf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    output logic               result_valid,
    input  logic               result_ready,
    output arf_pkg::ctrl_cmd_t cmd
);

    arf_pkg::state_t state_reg;
    arf_pkg::state_t state_next;
    logic            result_valid_reg;
    logic            result_valid_next;
    logic            slot_free;

    // output slot can take a new result
    assign slot_free = !result_valid_reg || result_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            arf_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = arf_pkg::ST_OUT;
                end
            end
            arf_pkg::ST_OUT:
            begin
                if (slot_free)
                begin
                    state_next = arf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = arf_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and commands
    always_comb
    begin
        item_ready = 1'b0;
        cmd.exec   = 1'b0;
        cmd.load   = 1'b0;
        case (state_reg)
            arf_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                cmd.exec   = item_valid;
            end
            arf_pkg::ST_OUT:
            begin
                cmd.load = slot_free;
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

    // result valid flag
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (cmd.load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    assign result_valid = result_valid_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= arf_pkg::ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

endmodule

// ----- sv/arf_datapath.sv -----
`timescale 1ns / 1ps
// datapath: sample memory, pointers, batch grant, prefill latch and result register
module arf_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  arf_pkg::ctrl_cmd_t         cmd,
    input  arf_pkg::item_t             item,
    input  logic                       cfg_we,
    input  logic [arf_pkg::THR_W-1:0]  cfg_data,
    output arf_pkg::result_t           result
);

    logic [arf_pkg::SAMPLE_W-1:0] mem [arf_pkg::FIFO_DEPTH];

    arf_pkg::ptr_t               wp_reg, wp_next;
    arf_pkg::ptr_t               rp_reg, rp_next;
    logic                        prefill_reached_reg, prefill_reached_next;
    logic                        granted_reg, granted_next;
    logic [arf_pkg::THR_W-1:0]   thr_reg;

    logic [arf_pkg::SAMPLE_W-1:0] rd_data_reg;
    logic                         pull_ok_reg;
    logic                         dropped_reg;
    logic                         under_reg;
    arf_pkg::ptr_t                fill_after_reg;
    arf_pkg::result_t             result_reg;

    arf_pkg::ptr_t fill;
    arf_pkg::cmp_t fill_c;
    arf_pkg::cmp_t free_c;
    arf_pkg::cmp_t len_c;
    arf_pkg::cmp_t thr_c;
    arf_pkg::cmp_t gated_c;
    logic          push_grant;
    logic          pull_grant;
    logic          reach_now;
    logic          grant_eff;
    logic          full;
    logic          empty;
    logic          do_push;
    logic          do_pull;

    // fill, free space and batch checks on the current beat
    always_comb
    begin
        fill       = wp_reg - rp_reg;
        fill_c     = arf_pkg::CMP_W'(fill);
        free_c     = arf_pkg::CMP_W'(arf_pkg::FIFO_DEPTH) - fill_c;
        len_c      = arf_pkg::CMP_W'(item.batch_length);
        thr_c      = arf_pkg::CMP_W'(thr_reg);
        push_grant = free_c >= len_c;
        reach_now  = prefill_reached_reg || (fill_c >= thr_c);
        gated_c    = reach_now ? fill_c : '0;
        pull_grant = gated_c >= len_c;
        if (item.batch_first)
        begin
            grant_eff = (item.mode == arf_pkg::MODE_PULL) ? pull_grant : push_grant;
        end
        else
        begin
            grant_eff = granted_reg;
        end
        full    = fill_c == arf_pkg::CMP_W'(arf_pkg::FIFO_DEPTH);
        empty   = fill == '0;
        do_push = (item.mode == arf_pkg::MODE_PUSH) && grant_eff && !full;
        do_pull = (item.mode == arf_pkg::MODE_PULL) && grant_eff && !empty;
    end

    // next control state on an executed beat
    always_comb
    begin
        wp_next              = wp_reg;
        rp_next              = rp_reg;
        granted_next         = granted_reg;
        prefill_reached_next = prefill_reached_reg;
        if (cmd.exec)
        begin
            if (item.batch_first)
            begin
                granted_next = grant_eff;
                if (item.mode == arf_pkg::MODE_PULL && reach_now)
                begin
                    prefill_reached_next = 1'b1;
                end
            end
            if (do_push)
            begin
                wp_next = wp_reg + arf_pkg::PTR_W'(1);
            end
            if (do_pull)
            begin
                rp_next = rp_reg + arf_pkg::PTR_W'(1);
            end
        end
    end

    // pointer, grant, prefill and threshold registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg              <= '0;
            rp_reg              <= '0;
            granted_reg         <= 1'b0;
            prefill_reached_reg <= 1'b0;
            thr_reg             <= arf_pkg::PREFILL_RESET;
        end
        else
        begin
            wp_reg              <= wp_next;
            rp_reg              <= rp_next;
            granted_reg         <= granted_next;
            prefill_reached_reg <= prefill_reached_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_data;
            end
        end
    end

    // sample memory: one write or one registered read per beat
    always_ff @(posedge clk)
    begin
        if (cmd.exec && do_push)
        begin
            mem[wp_reg[arf_pkg::ADDR_W-1:0]] <= item.sample_in;
        end
        if (cmd.exec && do_pull)
        begin
            rd_data_reg <= mem[rp_reg[arf_pkg::ADDR_W-1:0]];
        end
    end

    // per-beat outcome held until the result is formed
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            pull_ok_reg    <= do_pull;
            dropped_reg    <= (item.mode == arf_pkg::MODE_PUSH) && !do_push;
            under_reg      <= (item.mode == arf_pkg::MODE_PULL) && !do_pull;
            fill_after_reg <= wp_next - rp_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            result_reg.sample_out    <= pull_ok_reg ? rd_data_reg : '0;
            result_reg.batch_dropped <= dropped_reg;
            result_reg.underrun      <= under_reg;
            result_reg.fill_level    <= arf_pkg::LEVEL_W'(fill_after_reg);
        end
    end

    assign result = result_reg;

endmodule

// ----- sv/audio_ring_fifo_prefill.sv -----
`timescale 1ns / 1ps
// top level: ring fifo of stereo sample words with batch grant and prefill threshold
//
// Each accepted beat is handled in ST_IDLE, which checks the batch, updates the
// pointers and accesses the single-port sample memory, then in ST_OUT, which loads
// the result register from the registered memory read. The next beat is accepted
// while the previous result waits in the output register; a stalled result delays
// the block by holding ST_OUT. The prefill threshold is written through the cfg
// port while no beat is in flight, a rule for the user that the block does not
// enforce; it resets to 2400. Sample memory holds 4096 words and needs no clearing
// after reset, as a read can only reach entries already written.
module audio_ring_fifo_prefill (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  arf_pkg::item_t             item,
    output logic                       result_valid,
    input  logic                       result_ready,
    output arf_pkg::result_t           result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [arf_pkg::THR_W-1:0]  cfg_data
);

    arf_pkg::ctrl_cmd_t cmd;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    // controller
    arf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd)
    );

    // datapath
    arf_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .item     (item),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .result   (result)
    );

endmodule
